// File: hw/rtl/uart_rx_pkg.sv
// ---------------------------------------------------------------------------
// UART receive FIFO register block - shared types and constants
// Operation and register codes, character and status constants, stage types.
// ---------------------------------------------------------------------------
`default_nettype none

package uart_rx_pkg;

  typedef enum logic [1:0] {
    OP_RX    = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2,
    OP_SRST  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    REG_DATA   = 2'd0,
    REG_LSR    = 2'd1,
    REG_CTL    = 2'd2,
    REG_UNUSED = 2'd3
  } reg_e;

  localparam logic [7:0] CharCr  = 8'h0D;
  localparam logic [7:0] CharLf  = 8'h0A;
  localparam logic [7:0] LsrThre = 8'h20;

  typedef struct packed {
    op_e        op;
    reg_e       sel;
    logic [7:0] wdata;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       tx_flush;
    logic       irq;
    logic       pop;
  } res_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_req_t;

endpackage

`default_nettype wire

// File: hw/rtl/uart_rx_mem.sv
// ---------------------------------------------------------------------------
// UART receive FIFO storage
// Single write port, single read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module uart_rx_mem
  import uart_rx_pkg::*;
#(
  parameter int unsigned Depth = 256,
  parameter int unsigned Aw    = 8
) (
  input  wire logic          clk_i,
  input  wire mem_req_t      req_i,
  input  wire logic [Aw-1:0] wr_addr_i,
  input  wire logic [7:0]    wr_data_i,
  input  wire logic [Aw-1:0] rd_addr_i,
  output logic [7:0]         rd_data_o
);

  logic [7:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/uart_rx_ctrl.sv
// ---------------------------------------------------------------------------
// UART receive FIFO register control
// Decodes one transaction, updates FIFO pointers and control bits, builds result.
// ---------------------------------------------------------------------------
`default_nettype none

module uart_rx_ctrl
  import uart_rx_pkg::*;
#(
  parameter int unsigned Depth = 256,
  parameter int unsigned Aw    = 8
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic          cfg_data_i,
  input  wire logic          step_i,
  input  wire item_t         item_i,
  output res_t               res_o,
  output mem_req_t           req_o,
  output logic [Aw-1:0]      wr_addr_o,
  output logic [7:0]         wr_data_o,
  output logic [Aw-1:0]      rd_addr_o
);

  localparam logic [Aw:0]   CntFull = (Aw+1)'(Depth);
  localparam logic [Aw-1:0] PtrLast = Aw'(Depth - 1);

  logic          enable_q;
  logic [Aw-1:0] head_q, head_d, head_inc;
  logic [Aw:0]   count_q, count_d, tail_sum;
  logic          echo_q, echo_d;
  logic          irq_on_q, irq_on_d;
  logic          dr_q, dr_d;

  assign head_inc  = (head_q == PtrLast) ? '0 : head_q + 1'b1;
  assign tail_sum  = {1'b0, head_q} + count_q;
  assign rd_addr_o = head_q;
  assign wr_data_o = (item_i.rx_byte == CharCr) ? CharLf : item_i.rx_byte;

  always_comb begin
    head_d     = head_q;
    count_d    = count_q;
    echo_d     = echo_q;
    irq_on_d   = irq_on_q;
    dr_d       = dr_q;
    res_o      = '0;
    req_o      = '0;
    req_o.rd_en = step_i;
    wr_addr_o  = (tail_sum >= CntFull) ? Aw'(tail_sum - CntFull) : tail_sum[Aw-1:0];
    if (step_i && enable_q) begin
      case (item_i.op)
        OP_RX: begin
          req_o.wr_en = 1'b1;
          if (count_q == CntFull) begin
            head_d    = head_inc;
            wr_addr_o = head_q;
          end else begin
            count_d = count_q + 1'b1;
          end
          dr_d      = 1'b1;
          res_o.irq = irq_on_q;
        end
        OP_READ: begin
          case (item_i.sel)
            REG_DATA: begin
              if (count_q != '0) begin
                res_o.pop = 1'b1;
                head_d    = head_inc;
                count_d   = count_q - 1'b1;
                if (count_q == (Aw+1)'(1)) begin
                  dr_d = 1'b0;
                end
              end
            end
            REG_LSR: res_o.read_data = LsrThre | {7'b0, dr_q};
            REG_CTL: res_o.read_data = {7'b0, echo_q};
            default: res_o.read_data = '0;
          endcase
        end
        OP_WRITE: begin
          case (item_i.sel)
            REG_DATA: begin
              res_o.tx_valid = 1'b1;
              res_o.tx_byte  = item_i.wdata;
              res_o.tx_flush = echo_q;
            end
            REG_CTL: begin
              echo_d   = item_i.wdata[0];
              irq_on_d = item_i.wdata[1];
            end
            default: echo_d = echo_q;
          endcase
        end
        OP_SRST: begin
          head_d  = '0;
          count_d = '0;
          dr_d    = 1'b0;
          echo_d  = 1'b1;
        end
        default: head_d = head_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b1;
      head_q   <= '0;
      count_q  <= '0;
      echo_q   <= 1'b1;
      irq_on_q <= 1'b1;
      dr_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        enable_q <= cfg_data_i;
      end
      head_q   <= head_d;
      count_q  <= count_d;
      echo_q   <= echo_d;
      irq_on_q <= irq_on_d;
      dr_q     <= dr_d;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/uart_rx_fifo_registers_unit.sv
// ---------------------------------------------------------------------------
// UART receive FIFO register block - top level
// Bus register and receive path of a simple UART with a receive FIFO.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one transaction: a received
//   byte, a bus read, a bus write or a soft reset. Output channel (out_valid_o /
//   out_stall_i) returns exactly one result per transaction, in order.
//   Configuration channel (cfg_valid_i / cfg_ready_o) writes device_enable_i;
//   cfg_ready_o is always high. Write it only while the block is idle.
//   Path: input register, then result register with the FIFO read data register
//   beside it. Throughput: one transaction per cycle while out_stall_i is low;
//   the FIFO memory has one write and one read port, and a push and a pop never
//   come from the same transaction.
//   Reset: FIFO empty, echo and receive interrupt on, device enabled. The FIFO
//   storage is not cleared.
//   Stall: a waiting result holds the result register; the input register still
//   takes one more transaction, then in_stall_o rises until the result leaves.
// ---------------------------------------------------------------------------
`default_nettype none

module uart_rx_fifo_registers_unit
  import uart_rx_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = 256
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic       device_enable_i,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [1:0] operation_i,
  input  wire logic [1:0] reg_select_i,
  input  wire logic [7:0] write_data_i,
  input  wire logic [7:0] rx_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      read_data_o,
  output logic            tx_valid_o,
  output logic [7:0]      tx_byte_o,
  output logic            tx_flush_o,
  output logic            irq_pulse_o
);

  localparam int unsigned Aw = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

  logic          a_valid_q;
  item_t         a_item_q;
  logic          b_valid_q;
  res_t          b_res_q;
  logic          adv_b;
  logic          step;
  res_t          res;
  mem_req_t      mem_req;
  logic [Aw-1:0] wr_addr, rd_addr;
  logic [7:0]    wr_data, rd_data;

  assign cfg_ready_o = 1'b1;
  assign adv_b       = !b_valid_q || !out_stall_i;
  assign in_stall_o  = a_valid_q && !adv_b;
  assign step        = a_valid_q && adv_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        a_valid_q <= in_valid_i;
      end
      if (adv_b) begin
        b_valid_q <= a_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      a_item_q <= '{op: op_e'(operation_i), sel: reg_e'(reg_select_i),
                    wdata: write_data_i, rx_byte: rx_byte_i};
    end
    if (step) begin
      b_res_q <= res;
    end
  end

  uart_rx_ctrl #(
    .Depth (FIFO_DEPTH),
    .Aw    (Aw)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i),
    .cfg_data_i (device_enable_i),
    .step_i     (step),
    .item_i     (a_item_q),
    .res_o      (res),
    .req_o      (mem_req),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data),
    .rd_addr_o  (rd_addr)
  );

  uart_rx_mem #(
    .Depth (FIFO_DEPTH),
    .Aw    (Aw)
  ) u_mem (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign out_valid_o = b_valid_q;
  assign read_data_o = b_res_q.pop ? rd_data : b_res_q.read_data;
  assign tx_valid_o  = b_res_q.tx_valid;
  assign tx_byte_o   = b_res_q.tx_byte;
  assign tx_flush_o  = b_res_q.tx_flush;
  assign irq_pulse_o = b_res_q.irq;

endmodule

`default_nettype wire

// File: hw/rtl/uart_rx_chk.sv
// ---------------------------------------------------------------------------
// UART receive FIFO register block - port checker
// Checks result encoding, stall behavior and latency on the top-level ports.
// ---------------------------------------------------------------------------
`default_nettype none

module uart_rx_chk (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [7:0] read_data_o,
  input wire logic       tx_valid_o,
  input wire logic [7:0] tx_byte_o,
  input wire logic       tx_flush_o,
  input wire logic       irq_pulse_o
);

  a_tx_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !tx_valid_o |-> tx_byte_o == 8'h00 && !tx_flush_o)
    else $error("transmit fields set without transmit byte");

  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && tx_valid_o |-> !irq_pulse_o && read_data_o == 8'h00)
    else $error("transmit result mixed with read or interrupt");

  a_irq_no_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && irq_pulse_o |-> read_data_o == 8'h00)
    else $error("interrupt result carries read data");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) ##1 !out_stall_i |=> out_valid_o)
    else $error("result missing two cycles after transaction");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("stalled result dropped");

endmodule

bind uart_rx_fifo_registers_unit uart_rx_chk u_chk (.*);

`default_nettype wire
